// File: rtl/vsp_pkg.sv
// Package for the VAD segment post-processor.
// Holds shared constants, register indexes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package vsp_pkg;

    localparam int WINDOW_SAMPLES_DEF = 512;
    localparam int MAX_CHUNKS_DEF     = 32;

    localparam int ADDR_W = 5;
    localparam int REG_W  = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_W-1:0] REG_START_THR   = 3'd0;
    localparam logic [REG_W-1:0] REG_RELEASE_THR = 3'd1;
    localparam logic [REG_W-1:0] REG_MIN_SIL     = 3'd2;
    localparam logic [REG_W-1:0] REG_MIN_SPEECH  = 3'd3;
    localparam logic [REG_W-1:0] REG_PAD         = 3'd4;
    localparam logic [REG_W-1:0] REG_MAX_CHUNK   = 3'd5;

    // reset values of the registers
    localparam logic [15:0] RST_START_THR   = 16'd16384;
    localparam logic [15:0] RST_RELEASE_THR = 16'd11469;
    localparam logic [31:0] RST_MIN_SIL     = 32'd1600;
    localparam logic [31:0] RST_MIN_SPEECH  = 32'd4000;
    localparam logic [31:0] RST_PAD         = 32'd480;
    localparam logic [31:0] RST_MAX_CHUNK   = 32'd480000;

    // input operation codes
    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_END    = 1'b1;

    localparam int SUM_W  = 48;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_LAST = 6'd47;

    // controller to datapath commands
    typedef struct packed {
        logic step;   // apply the latched request to the hysteresis state
        logic close;  // merge the closed segment or retire the held one
        logic tail;   // end of audio: retire held segment, clear stream
        logic prep;   // pad, clamp and length check of the segment to emit
        logic div;    // one restoring division step
        logic chunk;  // produce one chunk
        logic flush;  // push the last pending result with tlast
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic op;
        logic close_req;
        logic emit_req;
        logic drop;
        logic div_done;
        logic chunk_last;
        logic can_put;
        logic flush_done;
    } t_stat;

endpackage

// File: rtl/vad_segment_postprocess_core.sv
// Top level of the VAD segment post-processor: stream ports, register
// port, controller and datapath. Depends on vsp_pkg, vsp_ctrl, vsp_datapath.
`timescale 1ns / 1ps

// Usage:
// The slave stream takes one request per audio window (tuser = 0, tdata
// carries the Q1.15 probability) or an end-of-audio request (tuser = 1,
// tdata carries the total sample count). The master stream returns speech
// chunks; tlast marks the final chunk caused by one request, and a request
// that causes no chunk returns nothing.
// One request is worked on at a time: a window request that closes no
// segment passes through step and flush; emitting a segment adds close,
// prep, the bit-serial averaging divider and one chunk per cycle while
// the result path has room; end of audio can emit two segments.
// The result path has a pending stage and an output register, so the
// block keeps working while one finished chunk waits on tready; when
// tready is low it stalls only once both stages are full.
// Reset (synchronous, active low) restores the registers to defaults and
// clears all stream state; there is no clearing pass. The user must write registers
// through the APB-style port while no request is in progress; the block does not check.
module vad_segment_postprocess_core #(
    parameter int WINDOW_SAMPLES = vsp_pkg::WINDOW_SAMPLES_DEF,
    parameter int MAX_CHUNKS     = vsp_pkg::MAX_CHUNKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,  // probability[15:0], total_samples[47:16]
    input  logic [0:0]                 s_axis_tuser,  // operation[0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [79:0]                m_axis_tdata,  // start[31:0], end[63:32], avg[79:64]
    output logic [0:0]                 m_axis_tuser,  // chunk_capped[0]
    output logic                       m_axis_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [15:0] r_start_thr, r_release_thr;
    logic [31:0] r_min_sil, r_min_speech, r_pad, r_max_chunk;

    vsp_pkg::t_cmd  cmd;
    vsp_pkg::t_stat stat;
    logic           in_accept;
    logic [vsp_pkg::REG_W-1:0] reg_idx;
    logic [31:0]    out_start, out_end;
    logic [15:0]    out_avg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[vsp_pkg::ADDR_W-1:2];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr   <= vsp_pkg::RST_START_THR;
            r_release_thr <= vsp_pkg::RST_RELEASE_THR;
            r_min_sil     <= vsp_pkg::RST_MIN_SIL;
            r_min_speech  <= vsp_pkg::RST_MIN_SPEECH;
            r_pad         <= vsp_pkg::RST_PAD;
            r_max_chunk   <= vsp_pkg::RST_MAX_CHUNK;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                vsp_pkg::REG_START_THR:   r_start_thr   <= pwdata[15:0];
                vsp_pkg::REG_RELEASE_THR: r_release_thr <= pwdata[15:0];
                vsp_pkg::REG_MIN_SIL:     r_min_sil     <= pwdata;
                vsp_pkg::REG_MIN_SPEECH:  r_min_speech  <= pwdata;
                vsp_pkg::REG_PAD:         r_pad         <= pwdata;
                vsp_pkg::REG_MAX_CHUNK:   r_max_chunk   <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            vsp_pkg::REG_START_THR:   prdata = {16'd0, r_start_thr};
            vsp_pkg::REG_RELEASE_THR: prdata = {16'd0, r_release_thr};
            vsp_pkg::REG_MIN_SIL:     prdata = r_min_sil;
            vsp_pkg::REG_MIN_SPEECH:  prdata = r_min_speech;
            vsp_pkg::REG_PAD:         prdata = r_pad;
            vsp_pkg::REG_MAX_CHUNK:   prdata = r_max_chunk;
            default:                  prdata = 32'd0;
        endcase
    end

    vsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vsp_datapath #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .MAX_CHUNKS     (MAX_CHUNKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_accept   (in_accept),
        .i_in_op       (s_axis_tuser[0]),
        .i_in_prob     (s_axis_tdata[15:0]),
        .i_in_total    (s_axis_tdata[47:16]),
        .i_start_thr   (r_start_thr),
        .i_release_thr (r_release_thr),
        .i_min_sil     (r_min_sil),
        .i_min_speech  (r_min_speech),
        .i_pad         (r_pad),
        .i_max_chunk   (r_max_chunk),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_start   (out_start),
        .o_out_end     (out_end),
        .o_out_avg     (out_avg),
        .o_out_capped  (m_axis_tuser[0]),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {out_avg, out_end, out_start};

endmodule

// File: rtl/vsp_ctrl.sv
// Controller state machine of the VAD segment post-processor.
// Sequences step, close, tail, emit (prep, divide, chunks) and flush.
// Depends on vsp_pkg.
`timescale 1ns / 1ps

module vsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  vsp_pkg::t_stat i_stat,
    output vsp_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_STEP  = 8'b0000_0010,
        S_CLOSE = 8'b0000_0100,
        S_TAIL  = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_CHUNK = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_tail_done, n_tail_done;
    t_state after_emit;

    // where to go once a segment has been emitted, dropped or not produced
    assign after_emit = (i_stat.op == vsp_pkg::OP_END && !r_tail_done) ? S_TAIL : S_FLUSH;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_tail_done = r_tail_done;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                n_tail_done = 1'b0;
                if (i_in_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = i_stat.close_req ? S_CLOSE : after_emit;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state = i_stat.emit_req ? S_PREP : after_emit;
            end
            S_TAIL: begin
                o_cmd.tail  = 1'b1;
                n_tail_done = 1'b1;
                n_state = i_stat.emit_req ? S_PREP : S_FLUSH;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_stat.drop ? after_emit : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_CHUNK;
                end
            end
            S_CHUNK: begin
                if (i_stat.can_put) begin
                    o_cmd.chunk = 1'b1;
                    if (i_stat.chunk_last) begin
                        n_state = after_emit;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_stat.flush_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tail_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail_done <= n_tail_done;
        end
    end

endmodule

// File: rtl/vsp_datapath.sv
// Datapath of the VAD segment post-processor: hysteresis state, held
// segment, padding, iterative averaging divider, chunk splitter, output
// stages. Depends on vsp_pkg.
`timescale 1ns / 1ps

module vsp_datapath #(
    parameter int WINDOW_SAMPLES = vsp_pkg::WINDOW_SAMPLES_DEF,
    parameter int MAX_CHUNKS     = vsp_pkg::MAX_CHUNKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vsp_pkg::t_cmd  i_cmd,
    output vsp_pkg::t_stat o_stat,
    input  logic           i_in_accept,
    input  logic           i_in_op,
    input  logic [15:0]    i_in_prob,
    input  logic [31:0]    i_in_total,
    input  logic [15:0]    i_start_thr,
    input  logic [15:0]    i_release_thr,
    input  logic [31:0]    i_min_sil,
    input  logic [31:0]    i_min_speech,
    input  logic [31:0]    i_pad,
    input  logic [31:0]    i_max_chunk,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [31:0]    o_out_start,
    output logic [31:0]    o_out_end,
    output logic [15:0]    o_out_avg,
    output logic           o_out_capped,
    output logic           o_out_last
);

    localparam int SW = vsp_pkg::SUM_W;
    localparam int KW = $clog2(MAX_CHUNKS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_CHUNKS - 1);

    // latched request
    logic        r_op;
    logic [15:0] r_prob;
    logic [31:0] r_total;

    // stream state
    logic [31:0]   r_pos;
    logic          r_trig;
    logic [31:0]   r_o_start;
    logic [SW-1:0] r_o_sum;
    logic [31:0]   r_o_cnt;
    logic          r_h_valid;
    logic [31:0]   r_h_start, r_h_end;
    logic [SW-1:0] r_h_sum;
    logic [31:0]   r_h_cnt;

    // closed segment
    logic [31:0]   r_c_start, r_c_end;
    logic [SW-1:0] r_c_sum;
    logic [31:0]   r_c_cnt;

    // segment being emitted
    logic [31:0]   r_e_start, r_e_end;
    logic [SW-1:0] r_e_sum;
    logic [31:0]   r_e_cnt;
    logic          r_e_clamp;

    // chunk splitter and divider
    logic [32:0]       r_t;
    logic [31:0]       r_pe, r_mx;
    logic              r_split;
    logic [KW-1:0]     r_k;
    logic [31:0]       r_rem;
    logic [SW-1:0]     r_quo;
    logic [vsp_pkg::DIV_CW-1:0] r_dcnt;

    // pending result and output register
    logic        r_pv;
    logic [31:0] r_p_start, r_p_end;
    logic [15:0] r_p_avg;
    logic        r_p_cap;
    logic        r_ov;
    logic [31:0] r_ob_start, r_ob_end;
    logic [15:0] r_ob_avg;
    logic        r_ob_cap, r_ob_last;

    // window hysteresis
    logic [31:0]   next_pos;
    logic          trig_on, trig_off;
    logic [SW:0]   o_sum_add;
    logic [32:0]   o_cnt_add;
    assign next_pos  = r_pos + 32'(WINDOW_SAMPLES);
    assign trig_on   = !r_trig && (r_prob >= i_start_thr);
    assign trig_off  = r_trig && (r_prob < i_release_thr);
    assign o_sum_add = {1'b0, r_o_sum} + (SW+1)'(r_prob);
    assign o_cnt_add = {1'b0, r_o_cnt} + 33'd1;

    // merge test and saturating merge
    logic signed [33:0] gap;
    logic               merge;
    logic [SW:0]        h_sum_add;
    logic [32:0]        h_cnt_add;
    assign gap       = $signed({2'b00, r_c_start}) - $signed({2'b00, r_h_end});
    assign merge     = r_h_valid && (gap < $signed({2'b00, i_min_sil}));
    assign h_sum_add = {1'b0, r_h_sum} + {1'b0, r_c_sum};
    assign h_cnt_add = {1'b0, r_h_cnt} + {1'b0, r_c_cnt};

    // padding, clamping, length check
    logic signed [32:0] seg_len;
    logic               drop;
    logic [31:0]        ps, pe, mx;
    logic [32:0]        pe_raw;
    always_comb begin
        seg_len = $signed({1'b0, r_e_end}) - $signed({1'b0, r_e_start});
        drop    = seg_len < $signed({1'b0, i_min_speech});
        ps      = (r_e_start > i_pad) ? r_e_start - i_pad : 32'd0;
        pe_raw  = {1'b0, r_e_end} + {1'b0, i_pad};
        if (r_e_clamp && pe_raw > {1'b0, r_total}) begin
            pe_raw = {1'b0, r_total};
        end
        pe = pe_raw[32] ? 32'hFFFF_FFFF : pe_raw[31:0];
        mx = (i_max_chunk == 32'd0) ? 32'd1 : i_max_chunk;
    end

    // restoring divider step
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {r_rem, r_quo[SW-1]};
    assign q_bit  = rem_sh >= {1'b0, r_e_cnt};

    // next chunk
    logic [32:0] ce;
    logic [31:0] c_end;
    logic        c_cap, c_last;
    logic [15:0] avg;
    always_comb begin
        ce     = r_t + {1'b0, r_mx};
        c_cap  = 1'b0;
        if (!r_split) begin
            c_end  = r_pe;
            c_last = 1'b1;
        end else if (r_k == K_LAST) begin
            c_cap  = ce < {1'b0, r_pe};
            c_end  = r_pe;
            c_last = 1'b1;
        end else begin
            c_end  = (ce > {1'b0, r_pe}) ? r_pe : ce[31:0];
            c_last = ce >= {1'b0, r_pe};
        end
        avg = (r_e_cnt == 32'd0) ? 16'd0 : r_quo[15:0];
    end

    logic out_free, load_out;
    assign out_free = !r_ov || i_out_ready;
    assign load_out = r_pv && (i_cmd.chunk || (i_cmd.flush && out_free));

    // status
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.close_req  = (r_op == vsp_pkg::OP_END) ? r_trig : trig_off;
        o_stat.emit_req   = i_cmd.tail ? r_h_valid : (r_h_valid && !merge);
        o_stat.drop       = drop;
        o_stat.div_done   = (r_dcnt == vsp_pkg::DIV_LAST);
        o_stat.chunk_last = c_last;
        o_stat.can_put    = !r_pv || out_free;
        o_stat.flush_done = !r_pv;
    end

    // request latch, stream state, held segment
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_op    <= i_in_op;
            r_prob  <= i_in_prob;
            r_total <= i_in_total;
        end
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_trig    <= 1'b0;
            r_o_start <= '0;
            r_o_sum   <= '0;
            r_o_cnt   <= '0;
            r_h_valid <= 1'b0;
            r_h_start <= '0;
            r_h_end   <= '0;
            r_h_sum   <= '0;
            r_h_cnt   <= '0;
        end else if (i_cmd.step) begin
            if (r_op == vsp_pkg::OP_WINDOW) begin
                r_pos <= next_pos;
                if (trig_on) begin
                    r_trig    <= 1'b1;
                    r_o_start <= r_pos;
                    r_o_sum   <= SW'(r_prob);
                    r_o_cnt   <= 32'd1;
                end else if (trig_off) begin
                    r_trig <= 1'b0;
                end else if (r_trig) begin
                    r_o_sum <= o_sum_add[SW] ? {SW{1'b1}} : o_sum_add[SW-1:0];
                    r_o_cnt <= o_cnt_add[32] ? 32'hFFFF_FFFF : o_cnt_add[31:0];
                end
            end
        end else if (i_cmd.close) begin
            if (merge) begin
                r_h_end <= r_c_end;
                r_h_sum <= h_sum_add[SW] ? {SW{1'b1}} : h_sum_add[SW-1:0];
                r_h_cnt <= h_cnt_add[32] ? 32'hFFFF_FFFF : h_cnt_add[31:0];
            end else begin
                r_h_valid <= 1'b1;
                r_h_start <= r_c_start;
                r_h_end   <= r_c_end;
                r_h_sum   <= r_c_sum;
                r_h_cnt   <= r_c_cnt;
            end
        end else if (i_cmd.tail) begin
            r_pos     <= '0;
            r_trig    <= 1'b0;
            r_o_start <= '0;
            r_o_sum   <= '0;
            r_o_cnt   <= '0;
            r_h_valid <= 1'b0;
            r_h_start <= '0;
            r_h_end   <= '0;
            r_h_sum   <= '0;
            r_h_cnt   <= '0;
        end
    end

    // closed segment and emitted segment capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_c_start <= r_o_start;
            r_c_end   <= (r_op == vsp_pkg::OP_END) ? r_total : next_pos;
            r_c_sum   <= r_o_sum;
            r_c_cnt   <= r_o_cnt;
        end
        if ((i_cmd.close && !merge) || i_cmd.tail) begin
            r_e_start <= r_h_start;
            r_e_end   <= r_h_end;
            r_e_sum   <= r_h_sum;
            r_e_cnt   <= r_h_cnt;
            r_e_clamp <= (r_op == vsp_pkg::OP_END);
        end
    end

    // prep, division and chunk walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_t     <= {1'b0, ps};
            r_pe    <= pe;
            r_mx    <= mx;
            r_split <= ($signed({1'b0, pe}) - $signed({1'b0, ps})) > $signed({1'b0, mx});
            r_rem   <= '0;
            r_quo   <= r_e_sum;
            r_dcnt  <= '0;
        end else if (i_cmd.div) begin
            r_rem  <= q_bit ? 32'(rem_sh - {1'b0, r_e_cnt}) : rem_sh[31:0];
            r_quo  <= {r_quo[SW-2:0], q_bit};
            r_dcnt <= r_dcnt + 1'b1;
        end else if (i_cmd.chunk) begin
            r_t <= {1'b0, c_end};
        end
        // chunk index stops at the last chunk of a segment
        if (!i_rst_n || i_cmd.prep) begin
            r_k <= '0;
        end else if (i_cmd.chunk && !c_last) begin
            r_k <= r_k + 1'b1;
        end
    end

    // pending slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.chunk) begin
                r_pv <= 1'b1;
            end else if (load_out) begin
                r_pv <= 1'b0;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_cmd.chunk) begin
            r_p_start <= r_t[31:0];
            r_p_end   <= c_end;
            r_p_avg   <= avg;
            r_p_cap   <= c_cap;
        end
        if (load_out) begin
            r_ob_start <= r_p_start;
            r_ob_end   <= r_p_end;
            r_ob_avg   <= r_p_avg;
            r_ob_cap   <= r_p_cap;
            r_ob_last  <= i_cmd.flush;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_start  = r_ob_start;
    assign o_out_end    = r_ob_end;
    assign o_out_avg    = r_ob_avg;
    assign o_out_capped = r_ob_cap;
    assign o_out_last   = r_ob_last;

`ifndef SYNTHESIS
    // a new chunk never overwrites a pending one the output cannot take
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.chunk && r_pv) |-> out_free)
        else $error("chunk produced with no room");

    // chunk counter stays within the chunk cap
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= K_LAST)
        else $error("chunk counter beyond cap");

    // end of audio returns stream state to reset
    a_tail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail |=> (!r_h_valid && !r_trig && r_pos == 32'd0))
        else $error("stream state not cleared");
`endif

endmodule
